/* design/ffba_pkg.sv */
package ffba_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int MAX_BLOCKS   = 256;
    localparam int HEADER_BYTES = 8;

    localparam int ADDR_W   = 17;
    localparam int NEED_W   = ADDR_W + 1;
    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int STATUS_W = 3;

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_REUSED   = 3'd0,
        ST_EXTENDED = 3'd1,
        ST_RELEASED = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_BADREL   = 3'd4
    } status_t;

    // Write port of the block list store.
    typedef struct packed
    {
        logic              flag_en;
        logic              len_en;
        logic [IDX_W-1:0]  addr;
        logic              flag;
        logic [ADDR_W-1:0] len;
    } store_wr_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } result_t;

endpackage

/* design/first_fit_block_allocator_unit.sv */
// First-fit heap allocator over a 64 KiB heap of up to 256 unsplit blocks, each with an
// 8-byte header. One word is handled at a time. An allocate or release walks the block
// list in address order and reads one header per cycle from the block store. The walk
// covers at most every block in the list, and a hit ends it early. The result waits in
// an output register, and the unit is ready for the next word in the cycle that the
// result shows up there, even while it is still held. The block store needs no clearing
// after reset, so the unit is ready at once.
module first_fit_block_allocator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [16:0] request_bytes, [33:17] release_address, rest zero
    input  logic [0:0]  s_tuser,  // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [16:0] user_address, rest zero
    output logic [2:0]  m_tuser   // [2:0] status
);

    ffba_pkg::store_wr_t           wr;
    ffba_pkg::result_t             res;
    logic                          res_valid, res_ready;
    logic                          rd_en, rd_flag;
    logic [ffba_pkg::IDX_W-1:0]    rd_addr;
    logic [ffba_pkg::ADDR_W-1:0]   rd_len;

    logic                          out_valid_reg, out_valid_next;
    ffba_pkg::result_t             out_reg, out_next;

    ffba_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_flag (rd_flag),
        .rd_len  (rd_len)
    );

    ffba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (ffba_pkg::op_t'(s_tuser[0])),
        .req_bytes (s_tdata[16:0]),
        .req_addr  (s_tdata[33:17]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr        (wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_flag   (rd_flag),
        .rd_len    (rd_len)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.addr};
    assign m_tuser  = out_reg.status;

endmodule

/* design/ffba_store.sv */
module ffba_store
(
    input  logic                           clk,
    input  ffba_pkg::store_wr_t            wr,
    input  logic                           rd_en,
    input  logic [ffba_pkg::IDX_W-1:0]     rd_addr,
    output logic                           rd_flag,
    output logic [ffba_pkg::ADDR_W-1:0]    rd_len
);

    logic                        flag_mem [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::ADDR_W-1:0] len_mem  [ffba_pkg::MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.flag_en)
        begin
            flag_mem[wr.addr] <= wr.flag;
        end
        if (wr.len_en)
        begin
            len_mem[wr.addr] <= wr.len;
        end
        if (rd_en)
        begin
            rd_flag <= flag_mem[rd_addr];
            rd_len  <= len_mem[rd_addr];
        end
    end

endmodule

/* design/ffba_ctrl.sv */
module ffba_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffba_pkg::op_t                  req_op,
    input  logic [ffba_pkg::ADDR_W-1:0]    req_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0]    req_addr,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ffba_pkg::result_t              res,
    output ffba_pkg::store_wr_t            wr,
    output logic                           rd_en,
    output logic [ffba_pkg::IDX_W-1:0]     rd_addr,
    input  logic                           rd_flag,
    input  logic [ffba_pkg::ADDR_W-1:0]    rd_len
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_EMIT
    } state_t;

    localparam logic [ffba_pkg::NEED_W-1:0] HDR  = ffba_pkg::NEED_W'(ffba_pkg::HEADER_BYTES);
    localparam logic [ffba_pkg::NEED_W-1:0] HEAP = ffba_pkg::NEED_W'(ffba_pkg::HEAP_BYTES);
    localparam logic [ffba_pkg::CNT_W-1:0]  MAXB = ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);

    state_t                        state_reg, state_next;
    ffba_pkg::op_t                 op_reg, op_next;
    logic [ffba_pkg::NEED_W-1:0]   key_reg, key_next;
    logic [ffba_pkg::NEED_W-1:0]   start_reg, start_next;
    logic [ffba_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [ffba_pkg::CNT_W-1:0]    total_reg, total_next;
    logic [ffba_pkg::ADDR_W-1:0]   brk_reg, brk_next;
    ffba_pkg::result_t             res_reg, res_next;

    logic [ffba_pkg::NEED_W-1:0]   add_a, add_b, add_sum, base, user;
    logic [ffba_pkg::NEED_W-1:0]   room;
    logic [ffba_pkg::CNT_W-1:0]    idx_inc;
    logic                          hit, last, extend_ok;

    // One adder serves the running block start during the walk and the
    // new break when a block is appended.
    always_comb
    begin
        if (state_reg == S_DECIDE)
        begin
            add_a = {1'b0, brk_reg};
            add_b = key_reg;
            base  = {1'b0, brk_reg};
        end
        else
        begin
            add_a = start_reg;
            add_b = {1'b0, rd_len};
            base  = start_reg;
        end
    end

    assign add_sum   = add_a + add_b;
    assign user      = base + HDR;
    assign room      = HEAP - {1'b0, brk_reg};
    assign idx_inc   = {1'b0, idx_reg} + ffba_pkg::CNT_W'(1);
    assign last      = (idx_inc == total_reg);
    assign extend_ok = (total_reg < MAXB) && (key_reg <= room);
    assign hit       = (op_reg == ffba_pkg::OP_ALLOC) ? (rd_flag && ({1'b0, rd_len} >= key_reg))
                                                      : (user == key_reg);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        start_next = start_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        brk_next   = brk_reg;
        res_next   = res_reg;
        wr         = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req_op;
                    key_next   = (req_op == ffba_pkg::OP_ALLOC) ? ({1'b0, req_bytes} + HDR)
                                                               : {1'b0, req_addr};
                    start_next = '0;
                    idx_next   = '0;
                    rd_en      = 1'b1;
                    state_next = (total_reg == '0) ? S_DECIDE : S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    wr.flag_en = 1'b1;
                    wr.addr    = idx_reg;
                    if (op_reg == ffba_pkg::OP_ALLOC)
                    begin
                        wr.flag  = 1'b0;
                        res_next = '{addr: user[ffba_pkg::ADDR_W-1:0],
                                     status: ffba_pkg::ST_REUSED};
                    end
                    else
                    begin
                        wr.flag  = 1'b1;
                        res_next = '{addr: '0, status: ffba_pkg::ST_RELEASED};
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    start_next = add_sum;
                    idx_next   = idx_inc[ffba_pkg::IDX_W-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[ffba_pkg::IDX_W-1:0];
                    if (last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (op_reg == ffba_pkg::OP_RELEASE)
                begin
                    res_next = '{addr: '0, status: ffba_pkg::ST_BADREL};
                end
                else if (extend_ok)
                begin
                    wr.flag_en = 1'b1;
                    wr.len_en  = 1'b1;
                    wr.addr    = total_reg[ffba_pkg::IDX_W-1:0];
                    wr.flag    = 1'b0;
                    wr.len     = key_reg[ffba_pkg::ADDR_W-1:0];
                    total_next = total_reg + ffba_pkg::CNT_W'(1);
                    brk_next   = add_sum[ffba_pkg::ADDR_W-1:0];
                    res_next   = '{addr: user[ffba_pkg::ADDR_W-1:0],
                                   status: ffba_pkg::ST_EXTENDED};
                end
                else
                begin
                    res_next = '{addr: '0, status: ffba_pkg::ST_NOSPACE};
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            brk_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            brk_reg   <= brk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        start_reg <= start_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAXB)
        else $error("block count exceeds list depth");

    a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, brk_reg} <= HEAP)
        else $error("heap break beyond heap end");

    a_extend_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr.len_en |=> (total_reg == $past(total_reg) + ffba_pkg::CNT_W'(1)))
        else $error("append did not grow the block count");

    a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (op_reg == ffba_pkg::OP_RELEASE) |->
            (res.status == ffba_pkg::ST_RELEASED || res.status == ffba_pkg::ST_BADREL))
        else $error("release produced an allocate status");
`endif

endmodule

/* test/allocator_checker.sv */
module allocator_checker
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,  // [16:0] request_bytes, [33:17] release_address, rest zero
    input  logic [0:0]  s_tuser,  // [0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,  // [16:0] user_address, rest zero
    input  logic [2:0]  m_tuser,  // [2:0] status
    output int          errors,
    output int          pending,
    output int          heap_left,
    output int          blocks_used
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the block list.
    logic              blk_free [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_len  [MAX_BLOCKS];
    int                blk_count = 0;
    int                heap_brk  = 0;
    int                err_count = 0;
    result_t           grant_queue[$];
    result_t           oldest;

    int errors_q      = 0;
    int pending_q     = 0;
    int heap_left_q   = HEAP_BYTES;
    int blocks_used_q = 0;

    assign errors      = errors_q;
    assign pending     = pending_q;
    assign heap_left   = heap_left_q;
    assign blocks_used = blocks_used_q;

    // Applies one word to the shadow list and returns the result it must produce.
    function automatic result_t walk_heap(op_t op, int req, int rel);
        result_t r;
        int      start;
        int      need;
        start    = 0;
        need     = req + HEADER_BYTES;
        r.addr   = '0;
        r.status = ST_BADREL;
        for (int i = 0; i < blk_count; i++)
        begin
            if (op == OP_ALLOC && blk_free[i] && int'(blk_len[i]) >= need)
            begin
                blk_free[i] = 1'b0;
                r.addr      = ADDR_W'(start + HEADER_BYTES);
                r.status    = ST_REUSED;
                return r;
            end
            if (op == OP_RELEASE && start + HEADER_BYTES == rel)
            begin
                blk_free[i] = 1'b1;
                r.status    = ST_RELEASED;
                return r;
            end
            start += int'(blk_len[i]);
        end
        if (op == OP_RELEASE)
            return r;
        if (blk_count >= MAX_BLOCKS || need > HEAP_BYTES - heap_brk)
        begin
            r.status = ST_NOSPACE;
            return r;
        end
        blk_free[blk_count] = 1'b0;
        blk_len[blk_count]  = ADDR_W'(need);
        blk_count++;
        r.addr   = ADDR_W'(heap_brk + HEADER_BYTES);
        r.status = ST_EXTENDED;
        heap_brk = heap_brk + need;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_queue.delete();
            blk_count     = 0;
            heap_brk      = 0;
            pending_q     <= 0;
            heap_left_q   <= HEAP_BYTES;
            blocks_used_q <= 0;
        end
        else
        begin
            // The result leaving now belongs to an older word than any accepted now.
            if (m_tvalid && m_tready)
            begin
                if (grant_queue.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: addr %0d status %0d",
                                              m_tdata[16:0], m_tuser));
                else
                begin
                    oldest = grant_queue.pop_front();
                    if (m_tdata[16:0] !== oldest.addr)
                        report_mismatch($sformatf("user_address expected %0d got %0d",
                                                  oldest.addr, m_tdata[16:0]));
                    if (m_tuser !== oldest.status)
                        report_mismatch($sformatf("status expected %s got %0d",
                                                  oldest.status.name(), m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                grant_queue.push_back(walk_heap(op_t'(s_tuser[0]), int'(s_tdata[16:0]),
                                                int'(s_tdata[33:17])));
            pending_q     <= grant_queue.size();
            heap_left_q   <= HEAP_BYTES - heap_brk;
            blocks_used_q <= blk_count;
        end
        errors_q <= err_count;
    end

endmodule

/* test/testbench.sv */
module testbench;
    import ffba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 240;
    localparam int DRAIN_CYCLES     = 300;
    localparam int POOL_MAX         = 600;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    int errors;
    int pending;
    int heap_left;
    int blocks_used;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_cnt      = 0;
    int quiet_cycles  = 0;

    // User addresses handed out so far; releases mostly pick from here.
    logic [ADDR_W-1:0] granted_addrs[$];

    always #5 clk = ~clk;

    first_fit_block_allocator_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    allocator_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .pending     (pending),
        .heap_left   (heap_left),
        .blocks_used (blocks_used)
    );

    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sampled mid-cycle, so the handshake at the next edge is certain and the
    // stimulus never reads the pool while it changes.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready &&
            (m_tuser == ST_REUSED || m_tuser == ST_EXTENDED))
        begin
            granted_addrs.push_back(m_tdata[ADDR_W-1:0]);
            if (granted_addrs.size() > POOL_MAX)
                granted_addrs.delete($urandom_range(granted_addrs.size() - 1));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input op_t op, input int req, input int rel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, ADDR_W'(rel), ADDR_W'(req)};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int pick_request();
        int k;
        k = $urandom_range(99);
        if (k < 80)
            return $urandom_range(0, 63);
        if (k < 92)
            return $urandom_range(64, 511);
        if (k < 96)
            return $urandom_range(512, 4095);
        if (k < 98)
            return $urandom_range(65529, 131071);
        return $urandom_range(65000, 65536);
    endfunction

    function automatic int pick_release();
        int k;
        int n;
        k = $urandom_range(99);
        n = granted_addrs.size();
        if (k < 70 && n > 0)
            return granted_addrs[$urandom_range(n - 1)];
        if (k < 85 && n > 0)
            return (granted_addrs[$urandom_range(n - 1)] + $urandom_range(1, 7)) % 131072;
        return $urandom_range(0, 131071);
    endfunction

    task automatic random_words(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 55)
                send_word(OP_ALLOC, pick_request(), $urandom_range(0, 131071));
            else
                send_word(OP_RELEASE, $urandom_range(0, 131071), pick_release());
        end
    endtask

    // Grows the list with header-only blocks to one short of full or until the heap runs low,
    // then lets the last block take exactly what is left of the heap and sends two more allocations.
    task automatic fill_heap_to_top();
        wait_drained();
        while (blocks_used < MAX_BLOCKS - 1 && heap_left >= 2 * HEADER_BYTES)
        begin
            send_word(OP_ALLOC, 0, $urandom_range(0, 131071));
            wait_drained();
        end
        if (blocks_used < MAX_BLOCKS && heap_left >= HEADER_BYTES)
        begin
            send_word(OP_ALLOC, heap_left - HEADER_BYTES, $urandom_range(0, 131071));
            wait_drained();
        end
        send_word(OP_ALLOC, 0, $urandom_range(0, 131071));
        send_word(OP_ALLOC, 65536, $urandom_range(0, 131071));
    endtask

    initial
    begin
        send_idle_pct = 14;
        recv_idle_pct <= 64;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty heap: the list below is built word by word, addresses in the notes.
        send_word(OP_ALLOC,   0,                        $urandom_range(0, 131071)); // 8
        send_word(OP_ALLOC,   100,                      $urandom_range(0, 131071)); // 16
        send_word(OP_ALLOC,   1,                        $urandom_range(0, 131071)); // 124
        send_word(OP_RELEASE, $urandom_range(0, 131071), 16);
        send_word(OP_RELEASE, $urandom_range(0, 131071), 16);  // already free
        send_word(OP_ALLOC,   100,                      $urandom_range(0, 131071)); // exact fit
        send_word(OP_RELEASE, $urandom_range(0, 131071), 16);
        send_word(OP_ALLOC,   101,                      $urandom_range(0, 131071)); // too big, 133
        send_word(OP_ALLOC,   0,                        $urandom_range(0, 131071)); // reuse 16
        send_word(OP_RELEASE, $urandom_range(0, 131071), 8);
        send_word(OP_ALLOC,   0,                        $urandom_range(0, 131071)); // reuse 8
        send_word(OP_RELEASE, $urandom_range(0, 131071), 0);
        send_word(OP_RELEASE, $urandom_range(0, 131071), 12);
        send_word(OP_RELEASE, $urandom_range(0, 131071), 131071);
        send_word(OP_RELEASE, $urandom_range(0, 131071), 242);  // address the next appended block would get
        send_word(OP_RELEASE, $urandom_range(0, 131071), 133);
        send_word(OP_ALLOC,   65536,                    $urandom_range(0, 131071));
        send_word(OP_ALLOC,   131071,                   $urandom_range(0, 131071));
        send_word(OP_ALLOC,   65295,                    $urandom_range(0, 131071)); // one byte over
        send_word(OP_ALLOC,   101,                      $urandom_range(0, 131071)); // reuse 133

        // The receiver stops for a long while so the unit backs up into its input.
        hold_asks <= hold_asks + 1;
        random_words(RANDOM_PER_PHASE);

        send_idle_pct = 64;
        recv_idle_pct <= 14;
        fill_heap_to_top();
        random_words(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_words(RANDOM_PER_PHASE);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
